### design/kus_pkg.sv
`timescale 1ns / 1ps

package kus_pkg;

   localparam int STACK_DEPTH_DEF = 128;
   localparam int KEY_W           = 32;
   localparam int PAYLOAD_W       = 32;
   localparam int POS_W           = 7;
   localparam int DEPTH_W         = 8;

   typedef enum logic [1:0] {
      OP_PUSH   = 2'd0,
      OP_POP    = 2'd1,
      OP_PEEK   = 2'd2,
      OP_SEARCH = 2'd3
   } op_type;

   typedef enum logic [2:0] {
      ST_OK       = 3'd0,
      ST_FULL     = 3'd1,
      ST_DUP      = 3'd2,
      ST_EMPTY    = 3'd3,
      ST_NOTFOUND = 3'd4
   } status_type;

   typedef struct packed {
      op_type                    req_type;
      logic signed [KEY_W-1:0]   key;
      logic [PAYLOAD_W-1:0]      payload;
   } req_data_type;

   typedef struct packed {
      status_type                status;
      logic signed [KEY_W-1:0]   found_key;
      logic [PAYLOAD_W-1:0]      found_payload;
      logic [POS_W-1:0]          position;
      logic [DEPTH_W-1:0]        depth_now;
   } rsp_data_type;

   typedef struct packed {
      logic signed [KEY_W-1:0]   key;
      logic [PAYLOAD_W-1:0]      payload;
   } record_type;

endpackage

### design/kus_store.sv
`timescale 1ns / 1ps

module kus_store #(
   parameter int DEPTH = kus_pkg::STACK_DEPTH_DEF,
   parameter int IW    = 7
) (
   input  logic                 clock,
   input  logic                 wr_en,
   input  logic [IW-1:0]        wr_addr,
   input  kus_pkg::record_type  wr_data,
   input  logic                 rd_en,
   input  logic [IW-1:0]        rd_addr,
   output kus_pkg::record_type  rd_data
);

   kus_pkg::record_type mem [DEPTH];
   kus_pkg::record_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### design/keyed_unique_stack.sv
`timescale 1ns / 1ps
// Bounded LIFO stack of records (unique signed key plus payload word).
// Request channel: req_valid / req_stall / req_data carries one request:
// push, pop, peek top or search by key. Response channel: rsp_valid /
// rsp_stall / rsp_data returns exactly one response per request, in order.
// Records live in a single-port-write, single-port-read RAM with a
// registered read; one key comparator walks the RAM from slot 0 upward.
// Path from request transfer to response valid:
//   full push, or pop/peek/search on an empty stack: straight to S_DONE
//   pop, peek: one RAM read in S_TOP, then S_DONE
//   push, search: S_SCAN walks the n records stored, one RAM
//   read and one compare per cycle; a match ends the walk early.
// One request is in work at a time: req_stall is high from the transfer
// until the response moves into the output register. A finished response
// waits in the output register while rsp_stall is high; the next request
// may be taken meanwhile and its own result holds until the register frees.
// Reset (synchronous, active high) empties the stack and drops any pending
// response; RAM contents are not cleared and need no clearing pass.
module keyed_unique_stack #(
   parameter int STACK_DEPTH = kus_pkg::STACK_DEPTH_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  kus_pkg::req_data_type  req_data,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output kus_pkg::rsp_data_type  rsp_data
);

   localparam int IW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
   localparam int CW = $clog2(STACK_DEPTH + 1);

   typedef enum logic [2:0] {
      S_IDLE,
      S_SCAN,
      S_TOP,
      S_DONE
   } state_type;

   state_type                        state_ff, state_in;
   kus_pkg::op_type                  op_ff, op_in;
   logic signed [kus_pkg::KEY_W-1:0] key_ff, key_in;
   logic [kus_pkg::PAYLOAD_W-1:0]    payload_ff, payload_in;
   logic [CW-1:0]                    count_ff, count_in;
   logic [CW-1:0]                    idx_ff, idx_in;
   logic                             pend_ff, pend_in;
   logic [IW-1:0]                    pend_idx_ff, pend_idx_in;
   kus_pkg::rsp_data_type            res_ff, res_in;
   logic                             rsp_valid_ff, rsp_valid_in;
   kus_pkg::rsp_data_type            rsp_ff, rsp_in;

   logic                             rd_en;
   logic [IW-1:0]                    rd_addr;
   logic                             wr_en;
   logic [IW-1:0]                    wr_addr;
   kus_pkg::record_type              wr_data;
   kus_pkg::record_type              rd_data;

   logic [CW-1:0]                    count_inc;
   logic [CW-1:0]                    top_slot;

   kus_store #(
      .DEPTH (STACK_DEPTH),
      .IW    (IW)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign count_inc = count_ff + CW'(1);
   assign top_slot  = count_ff - CW'(1);

   always_comb begin
      state_in     = state_ff;
      op_in        = op_ff;
      key_in       = key_ff;
      payload_in   = payload_ff;
      count_in     = count_ff;
      idx_in       = idx_ff;
      pend_in      = pend_ff;
      pend_idx_in  = pend_idx_ff;
      res_in       = res_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_in       = rsp_ff;

      rd_en        = 1'b0;
      rd_addr      = idx_ff[IW-1:0];
      wr_en        = 1'b0;
      wr_addr      = count_ff[IW-1:0];
      wr_data      = '{key: key_ff, payload: payload_ff};

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               op_in      = req_data.req_type;
               key_in     = req_data.key;
               payload_in = req_data.payload;
               idx_in     = '0;
               pend_in    = 1'b0;
               res_in     = '{status: kus_pkg::ST_EMPTY, found_key: '0, found_payload: '0,
                              position: '0, depth_now: kus_pkg::DEPTH_W'(count_ff)};
               unique case (req_data.req_type)
                  kus_pkg::OP_PUSH: begin
                     if (count_ff == CW'(STACK_DEPTH)) begin
                        res_in.status = kus_pkg::ST_FULL;
                        state_in      = S_DONE;
                     end else begin
                        state_in = S_SCAN;
                     end
                  end
                  kus_pkg::OP_POP, kus_pkg::OP_PEEK: begin
                     if (count_ff == '0) begin
                        state_in = S_DONE;
                     end else begin
                        rd_en    = 1'b1;
                        rd_addr  = top_slot[IW-1:0];
                        state_in = S_TOP;
                     end
                  end
                  default: begin
                     state_in = (count_ff == '0) ? S_DONE : S_SCAN;
                  end
               endcase
            end
         end

         S_SCAN: begin
            if (pend_ff && rd_data.key == key_ff) begin
               res_in.position = kus_pkg::POS_W'(pend_idx_ff);
               if (op_ff == kus_pkg::OP_PUSH) begin
                  res_in.status = kus_pkg::ST_DUP;
               end else begin
                  res_in.status        = kus_pkg::ST_OK;
                  res_in.found_key     = rd_data.key;
                  res_in.found_payload = rd_data.payload;
               end
               state_in = S_DONE;
            end else if (idx_ff < count_ff) begin
               // issue the next slot while comparing the previous one
               rd_en       = 1'b1;
               pend_in     = 1'b1;
               pend_idx_in = idx_ff[IW-1:0];
               idx_in      = idx_ff + CW'(1);
            end else begin
               // walked every record without a match
               if (op_ff == kus_pkg::OP_PUSH) begin
                  wr_en            = 1'b1;
                  count_in         = count_inc;
                  res_in.status    = kus_pkg::ST_OK;
                  res_in.position  = kus_pkg::POS_W'(count_ff);
                  res_in.depth_now = kus_pkg::DEPTH_W'(count_inc);
               end else begin
                  res_in.status = kus_pkg::ST_NOTFOUND;
               end
               state_in = S_DONE;
            end
         end

         S_TOP: begin
            res_in.status        = kus_pkg::ST_OK;
            res_in.found_key     = rd_data.key;
            res_in.found_payload = rd_data.payload;
            res_in.position      = kus_pkg::POS_W'(top_slot);
            if (op_ff == kus_pkg::OP_POP) begin
               count_in         = top_slot;
               res_in.depth_now = kus_pkg::DEPTH_W'(top_slot);
            end
            state_in = S_DONE;
         end

         S_DONE: begin
            // hold until the output register is free
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               rsp_in       = res_ff;
               state_in     = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      op_ff       <= op_in;
      key_ff      <= key_in;
      payload_ff  <= payload_in;
      idx_ff      <= idx_in;
      pend_idx_ff <= pend_idx_in;
      res_ff      <= res_in;
      rsp_ff      <= rsp_in;
   end

   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule
